[rtl/core/pf2m_pkg.sv]
// Shared types and constants for the PCM frame to mono 16-bit decoder.
package pf2m_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_SAMPLE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;

  // Reset values of the configuration registers (16-bit mono).
  localparam logic [1:0] WIDTH_CODE_RESET = 2'd1;
  localparam logic [1:0] CHANNELS_RESET   = 2'd1;

  // Offset-binary bias of 8-bit samples; subtracting it flips the top bit.
  localparam logic [7:0] BIAS_8BIT = 8'h80;

  typedef struct packed {
    logic [1:0] width_code;
    logic [1:0] channel_count;
  } cfg_t;

endpackage

[rtl/core/pf2m_in_reg.sv]
// Input register stage that holds one accepted byte until the decoder consumes it.
module pf2m_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  input  logic       pop,
  output logic       s1_valid,
  output logic [7:0] s1_byte,
  output logic       s1_start
);

  assign in_ready = !s1_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_start <= frame_start;
    end
  end

endmodule

[rtl/core/pf2m_decode.sv]
// Frame position tracking, sample assembly and stereo averaging for one byte per cycle unless stalled.
module pf2m_decode (
  input  logic               clk,
  input  logic               rst,
  input  pf2m_pkg::cfg_t     cfg,
  input  logic               s1_valid,
  input  logic [7:0]         s1_byte,
  input  logic               s1_start,
  input  logic               out_can_take,
  output logic               pop,
  output logic               res_valid,
  output logic signed [15:0] res_sample
);

  logic [2:0]         byte_position;
  logic [7:0]         held_low_byte;
  logic signed [15:0] left_value;

  logic [2:0]         bpc;
  logic               stereo;
  logic [3:0]         frame_bytes;
  logic [2:0]         pos_raw;
  logic [2:0]         pos;
  logic               chan;
  logic [2:0]         off;
  logic [3:0]         pos_inc;
  logic               last;
  logic               is_low;
  logic               is_top;
  logic signed [15:0] value;
  logic signed [16:0] sum;

  always_comb begin
    bpc         = {1'b0, cfg.width_code} + 3'd1;
    stereo      = cfg.channel_count[1];
    frame_bytes = stereo ? {bpc, 1'b0} : {1'b0, bpc};
    pos_raw     = s1_start ? 3'd0 : byte_position;
    // A frame shrunk by a register write restarts at its first byte.
    pos         = ({1'b0, pos_raw} >= frame_bytes) ? 3'd0 : pos_raw;
    chan        = (pos >= bpc);
    off         = pos - (chan ? bpc : 3'd0);
    pos_inc     = {1'b0, pos} + 4'd1;
    last        = (pos_inc >= frame_bytes);
    is_low      = (bpc >= 3'd2) && (off == bpc - 3'd2);
    is_top      = (off == bpc - 3'd1);
    if (bpc == 3'd1) begin
      value = {s1_byte ^ pf2m_pkg::BIAS_8BIT, 8'h00};
    end else begin
      value = {s1_byte, held_low_byte};
    end
    sum        = {left_value[15], left_value} + {value[15], value};
    res_sample = stereo ? sum[16:1] : value;
    res_valid  = s1_valid && is_top && last && !(stereo && !chan);
    pop        = s1_valid && (!res_valid || out_can_take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      held_low_byte <= 8'd0;
      left_value    <= 16'sd0;
    end else if (pop) begin
      byte_position <= last ? 3'd0 : pos_inc[2:0];
      if (is_low) begin
        held_low_byte <= s1_byte;
      end
      if (is_top && stereo && !chan) begin
        left_value <= value;
      end
    end
  end

`ifndef SYNTHESIS
  a_wrap_to_zero: assert property (@(posedge clk) disable iff (rst)
    (pop && last) |=> (byte_position == 3'd0))
    else $error("frame end did not return byte position to zero");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (pop && !last) |=> (byte_position == $past(pos) + 3'd1))
    else $error("byte position did not advance by one");

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (last && is_top))
    else $error("result raised on a byte that does not end a frame");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !pop) |=> $stable(byte_position))
    else $error("state moved while the word was held");
`endif

endmodule

[rtl/core/pf2m_out_reg.sv]
// Result register that holds one mono sample until the consumer takes it.
module pf2m_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic signed [15:0] push_sample,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] mono_sample,
  output logic               can_take
);

  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mono_sample <= push_sample;
    end
  end

endmodule

[rtl/core/pcm_frame_to_mono16.sv]
// An accepted byte sits in the input register; its sample is registered in the result register.
// One word per cycle while the result register can take each sample; a frame of N bytes gives one.
// The single decode stage lies between the input register and the result register.
// Reset (synchronous, active high) empties both registers and restores 16-bit mono.
// The byte position, held low byte and left sample reset to zero.
module pcm_frame_to_mono16 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] mono_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data
);

  // Configuration registers. Writes are always taken; an index outside the
  // register list is ignored.
  pf2m_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_code    <= pf2m_pkg::WIDTH_CODE_RESET;
      cfg.channel_count <= pf2m_pkg::CHANNELS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pf2m_pkg::REG_SAMPLE_WIDTH:  cfg.width_code    <= cfg_data;
        pf2m_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input register holds one word; it refills in the same cycle the
  // decoder consumes it, so bytes stream at one per clock unless the decoder holds its byte.
  logic        pop;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_start;

  pf2m_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .pop         (pop),
    .s1_valid    (s1_valid),
    .s1_byte     (s1_byte),
    .s1_start    (s1_start)
  );

  // The decoder consumes a byte whenever it produces no sample, or when the
  // result register can take the sample. Bytes that only feed the frame
  // keep flowing even while a finished sample waits at the output.
  logic               res_valid;
  logic signed [15:0] res_sample;
  logic               out_can_take;

  pf2m_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .s1_valid     (s1_valid),
    .s1_byte      (s1_byte),
    .s1_start     (s1_start),
    .out_can_take (out_can_take),
    .pop          (pop),
    .res_valid    (res_valid),
    .res_sample   (res_sample)
  );

  // The result register separates the decoder from the consumer.
  pf2m_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .push        (res_valid && out_can_take),
    .push_sample (res_sample),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .mono_sample (mono_sample),
    .can_take    (out_can_take)
  );

endmodule

[test/tb_pcm_frame_to_mono16.sv]
// Self-checking testbench for the byte-serial PCM frame to 16-bit mono decoder.
`timescale 1ns / 1ps

module tb_pcm_frame_to_mono16;

  // The watchdog gives up after this many cycles without any handshake.
  localparam int unsigned HANG_LIMIT    = 2000;
  // Quiet cycles required before a register write or a sender pause ends.
  // The block has one decode stage plus a result register, so a few cycles
  // cover a byte that is still in flight but causes no sample.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Cycles watched after the last sample for anything unexpected.
  localparam int unsigned TAIL_CYCLES   = 20;
  // Rough number of random bytes to send.
  localparam int unsigned RANDOM_BYTES  = 1600;

  typedef enum logic [1:0] {
    STEP_BYTE,   // one word on the byte channel
    STEP_REG,    // one register write, issued only once the block is idle
    STEP_DRAIN   // hold the sender until every sample has come back
  } step_kind_t;

  typedef struct {
    step_kind_t kind;
    logic [7:0] data;
    logic       sof;
    logic [1:0] reg_index;
    logic [1:0] reg_value;
  } pcm_step_t;

  // Every driven input starts at a known value at time zero.
  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic [7:0]         data_byte   = 8'h00;
  logic               frame_start = 1'b0;
  logic               out_ready   = 1'b0;
  logic               cfg_valid   = 1'b0;
  logic [1:0]         cfg_index   = pf2m_pkg::REG_SAMPLE_WIDTH;
  logic [1:0]         cfg_data    = 2'd0;
  logic               in_ready;
  logic               out_valid;
  logic               cfg_ready;
  logic signed [15:0] mono_sample;

  pcm_frame_to_mono16 dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mono_sample (mono_sample),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work still to be sent, and the samples the decoder is expected to give.
  pcm_step_t          pcm_steps[$];
  logic signed [15:0] pending_samples[$];

  // Handshake bookkeeping between the edge that samples and the edge that drives.
  logic        in_took  = 1'b0;
  logic        cfg_took = 1'b0;
  int unsigned quiet    = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_queued = 0;

  // Shadow copy of the decoder: its registers and its frame assembly state.
  logic [1:0]         width_cfg;
  logic [1:0]         chan_cfg;
  logic [2:0]         pos_st;
  logic [7:0]         low_st;
  logic signed [15:0] left_st;

  // Pacing state for both sides.
  int unsigned gap_left   = 0;
  int unsigned calm_left  = 0;
  int unsigned ready_hold = 0;

  // Advance the shadow decoder by one accepted word and queue any sample it
  // completes. Bytes below the top two of a wide sample are dropped, the
  // byte just under the top one is held, and the top byte finishes a channel.
  task automatic decode_pcm_byte(input logic [7:0] b, input logic sof);
    logic [2:0]         bpc;
    logic               stereo;
    logic [3:0]         flen;
    logic [3:0]         pos;
    logic [3:0]         off;
    logic               ch1;
    logic               last;
    logic signed [15:0] s;
    logic signed [16:0] sum;
    bpc    = {1'b0, width_cfg} + 3'd1;
    // A channel count of zero acts as mono, three acts as stereo.
    stereo = chan_cfg >= 2'd2;
    flen   = stereo ? {bpc, 1'b0} : {1'b0, bpc};
    // A frame start realigns; a position left outside a frame that a
    // register write has shrunk also counts as the first byte.
    pos = sof ? 4'd0 : {1'b0, pos_st};
    if (pos >= flen) begin
      pos = 4'd0;
    end
    ch1    = pos >= {1'b0, bpc};
    off    = ch1 ? pos - {1'b0, bpc} : pos;
    last   = (pos + 4'd1) >= flen;
    pos_st = last ? 3'd0 : pos[2:0] + 3'd1;
    if (bpc >= 3'd2 && off == {1'b0, bpc} - 4'd2) begin
      low_st = b;
      return;
    end
    if (off != {1'b0, bpc} - 4'd1) begin
      return;
    end
    if (bpc == 3'd1) begin
      // Unsigned 8-bit audio: removing the bias and scaling up by 256.
      s = {b - pf2m_pkg::BIAS_8BIT, 8'h00};
    end else begin
      s = {b, low_st};
    end
    if (stereo && !ch1) begin
      left_st = s;
      return;
    end
    if (!last) begin
      return;
    end
    if (stereo) begin
      // Floor of the average: the 17-bit sum shifted right arithmetically.
      sum = left_st + s;
      s   = sum[16:1];
    end
    pending_samples.push_back(s);
  endtask

  task automatic report_mismatch(input logic stray, input logic signed [15:0] want,
                                 input logic signed [15:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      if (stray) begin
        $display("%0t: unexpected sample %0d with nothing pending", $realtime, got);
      end else begin
        $display("%0t: sample mismatch, expected %0d got %0d", $realtime, want, got);
      end
    end
  endtask

  // Monitor: samples every handshake at the rising edge, runs the shadow
  // decoder on accepted words and register writes, and checks each sample.
  always @(posedge clk) begin : monitor
    logic signed [15:0] want;
    in_took  <= in_valid && in_ready;
    cfg_took <= cfg_valid && cfg_ready;
    if (rst) begin
      width_cfg = pf2m_pkg::WIDTH_CODE_RESET;
      chan_cfg  = pf2m_pkg::CHANNELS_RESET;
      pos_st    = 3'd0;
      low_st    = 8'h00;
      left_st   = 16'sd0;
      quiet     <= 0;
    end else begin
      // Register writes only happen while no word is on the byte channel,
      // so their order against the decoder does not matter here.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pf2m_pkg::REG_SAMPLE_WIDTH) begin
          width_cfg = cfg_data;
        end else if (cfg_index == pf2m_pkg::REG_CHANNEL_COUNT) begin
          chan_cfg = cfg_data;
        end
      end
      if (out_valid && out_ready) begin
        if (pending_samples.size() == 0) begin
          report_mismatch(1'b1, 16'sd0, mono_sample);
        end else begin
          want = pending_samples.pop_front();
          if (mono_sample !== want) begin
            report_mismatch(1'b0, want, mono_sample);
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_pcm_byte(data_byte, frame_start);
      end
      // The block counts as idle once nothing moves and nothing is owed.
      if (in_valid || out_valid || pending_samples.size() != 0) begin
        quiet <= 0;
      end else if (quiet < SETTLE_CYCLES) begin
        quiet <= quiet + 1;
      end
    end
  end

  // Driver: changes inputs at the falling edge. A word stays on the channel
  // until the rising edge that takes it; only then is the next step looked at.
  always @(negedge clk) begin : feed
    logic load_byte;
    logic load_reg;
    load_byte = 1'b0;
    load_reg  = 1'b0;
    if (!rst && !(in_valid && !in_took) && !(cfg_valid && !cfg_took)) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pcm_steps.size() != 0) begin
        case (pcm_steps[0].kind)
          STEP_BYTE: begin
            load_byte = 1'b1;
            data_byte   <= pcm_steps[0].data;
            frame_start <= pcm_steps[0].sof;
            void'(pcm_steps.pop_front());
            // Mostly back to back or short gaps, now and then a long one,
            // and from time to time a long stretch with no gaps at all.
            if (calm_left != 0) begin
              calm_left--;
            end else if ($urandom_range(63) == 0) begin
              calm_left = $urandom_range(120, 30);
            end else begin
              case ($urandom_range(9)) inside
                [0:4]:   gap_left = 0;
                [5:8]:   gap_left = $urandom_range(3, 1);
                default: gap_left = $urandom_range(40, 8);
              endcase
            end
          end
          STEP_REG: begin
            if (quiet >= SETTLE_CYCLES) begin
              load_reg = 1'b1;
              cfg_index <= pcm_steps[0].reg_index;
              cfg_data  <= pcm_steps[0].reg_value;
              void'(pcm_steps.pop_front());
            end
          end
          default: begin
            if (quiet >= SETTLE_CYCLES) begin
              void'(pcm_steps.pop_front());
            end
          end
        endcase
      end
      in_valid  <= load_byte;
      cfg_valid <= load_reg;
    end
  end

  // Sink side: ready is held for runs of random length, mostly high with
  // short stalls, sometimes a long stall, sometimes a long run with none.
  always @(negedge clk) begin : sink
    logic take;
    take = out_ready;
    if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      case ($urandom_range(99)) inside
        [0:54]:  begin take = 1'b1; ready_hold = $urandom_range(20); end
        [55:89]: begin take = 1'b0; ready_hold = $urandom_range(3); end
        [90:95]: begin take = 1'b0; ready_hold = $urandom_range(50, 10); end
        default: begin take = 1'b1; ready_hold = $urandom_range(200, 80); end
      endcase
    end
    out_ready <= take;
  end

  function automatic logic [7:0] pcm_byte_value();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic sof);
    pcm_step_t st;
    st = '{kind: STEP_BYTE, data: b, sof: sof, reg_index: pf2m_pkg::REG_SAMPLE_WIDTH,
           reg_value: 2'd0};
    pcm_steps.push_back(st);
    bytes_queued++;
  endtask

  task automatic push_reg(input logic [1:0] idx, input logic [1:0] value);
    pcm_step_t st;
    st = '{kind: STEP_REG, data: 8'h00, sof: 1'b0, reg_index: idx, reg_value: value};
    pcm_steps.push_back(st);
  endtask

  task automatic push_drain();
    pcm_step_t st;
    st = '{kind: STEP_DRAIN, data: 8'h00, sof: 1'b0,
           reg_index: pf2m_pkg::REG_SAMPLE_WIDTH, reg_value: 2'd0};
    pcm_steps.push_back(st);
  endtask

  // Random content for n bytes; only the first may carry a frame start.
  task automatic push_frame(input int unsigned n, input logic sof);
    for (int unsigned i = 0; i < n; i++) begin
      push_byte(pcm_byte_value(), (i == 0) ? sof : 1'b0);
    end
  endtask

  // Stimulus and end of run.
  initial begin : run
    logic [1:0]  gen_w;
    logic [1:0]  gen_c;
    int unsigned flen;
    int unsigned frames;
    int unsigned which;
    int unsigned limit;
    logic        misaligned;

    // Directed part, starting from 16-bit mono after reset.
    // Most negative and most positive 16-bit samples.
    push_byte(8'h00, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    // A frame start mid-frame throws the half-built sample away.
    push_byte(8'h34, 1'b0);
    push_byte(8'h12, 1'b1);
    push_byte(8'hAB, 1'b0);
    // 8-bit unsigned samples at both ends of the range.
    push_reg(pf2m_pkg::REG_SAMPLE_WIDTH, 2'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // 32-bit stereo: low bytes are ignored, and the extremes average to -1.
    push_reg(pf2m_pkg::REG_SAMPLE_WIDTH, 2'd3);
    push_reg(pf2m_pkg::REG_CHANNEL_COUNT, 2'd2);
    push_byte(8'h11, 1'b1);
    push_byte(8'h22, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    // Leave a stereo frame half done, then shrink the frame to one byte:
    // the stale position lies outside the new frame. A channel count of
    // zero must behave as mono.
    push_frame(5, 1'b1);
    push_reg(pf2m_pkg::REG_SAMPLE_WIDTH, 2'd0);
    push_reg(pf2m_pkg::REG_CHANNEL_COUNT, 2'd0);
    push_byte(8'h7F, 1'b0);
    // Hold the sender once until every sample is back.
    push_drain();
    // 24-bit with a channel count of three, which acts as stereo; both
    // channels at the bottom of the range.
    push_reg(pf2m_pkg::REG_SAMPLE_WIDTH, 2'd2);
    push_reg(pf2m_pkg::REG_CHANNEL_COUNT, 2'd3);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);

    // Random part: phases of well-formed frames under one setting, with
    // some broken frames and noise mixed in. A phase may end mid-frame so
    // the next register write lands on a partly built frame.
    gen_w = 2'd2;
    gen_c = 2'd3;
    limit = bytes_queued + RANDOM_BYTES;
    while (bytes_queued < limit) begin
      which = $urandom_range(3);
      if (which != 1) begin
        gen_w = 2'($urandom_range(3));
        push_reg(pf2m_pkg::REG_SAMPLE_WIDTH, gen_w);
      end
      if (which != 2) begin
        gen_c = 2'($urandom_range(3));
        push_reg(pf2m_pkg::REG_CHANNEL_COUNT, gen_c);
      end
      flen = (gen_w + 1) * ((gen_c >= 2) ? 2 : 1);
      frames = $urandom_range(30, 4);
      misaligned = 1'b0;
      for (int unsigned f = 0; f < frames; f++) begin
        which = $urandom_range(99);
        if (which < 80) begin
          push_frame(flen, misaligned ? 1'b1 : 1'($urandom_range(1)));
          misaligned = 1'b0;
        end else if (which < 90) begin
          push_frame($urandom_range(flen, 1), 1'($urandom_range(1)));
          misaligned = 1'b1;
        end else begin
          for (int unsigned k = $urandom_range(6, 1); k != 0; k--) begin
            push_byte(pcm_byte_value(), 1'($urandom_range(1)));
          end
          misaligned = 1'b1;
        end
        if ($urandom_range(60) == 0) begin
          push_drain();
        end
      end
      if (flen > 1 && $urandom_range(1) == 1) begin
        push_frame($urandom_range(flen - 1, 1), 1'($urandom_range(1)));
      end
    end

    // Reset is held from time zero and released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pcm_steps.size() != 0 || in_valid || cfg_valid || pending_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: a run where no handshake completes for a long stretch is hung.
  initial begin : watchdog
    int unsigned hung;
    hung = 0;
    while (hung < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        hung = 0;
      end else begin
        hung++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule

[pcm_frame_to_mono16.f]
rtl/core/pf2m_pkg.sv
rtl/core/pf2m_in_reg.sv
rtl/core/pf2m_decode.sv
rtl/core/pf2m_out_reg.sv
rtl/core/pcm_frame_to_mono16.sv
test/tb_pcm_frame_to_mono16.sv
